// ===== rtl/core/sse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, constants and helpers for sprite scanline evaluation.
// ----------------------------------------------------------------------------
package sse_pkg;

    // table and line sizing
    localparam int TABLE_ENTRIES = 64;
    localparam int LINE_SLOTS    = 16;
    localparam int SLOT_CNT_W    = $clog2(LINE_SLOTS + 1);

    // queue depths (powers of two, pointers wrap naturally)
    localparam int MID_DEPTH  = 2;
    localparam int MID_PTR_W  = $clog2(MID_DEPTH);
    localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH  = 2;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // entry decode constants
    localparam logic [9:0]  Y_MASK      = 10'h3FF;
    localparam logic [11:0] Y_OFFSET    = 12'd64;
    localparam logic [15:0] ATTR_MASK   = 16'hFFCF;
    localparam logic [15:0] ATTR_FIRST  = 16'h0010;
    localparam logic [8:0]  INDEX_LIMIT = 9'(TABLE_ENTRIES);

    // result kinds
    localparam logic KIND_STORE    = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    // height codes
    localparam logic [1:0] HCODE_32 = 2'd1;
    localparam logic [1:0] HCODE_64 = 2'd3;

    // input transaction
    typedef struct packed {
        logic signed [9:0] line;
        logic [5:0]        entry_index;
        logic [15:0]       y_word;
        logic [15:0]       x_word;
        logic [15:0]       pattern_word;
        logic [15:0]       attr_word;
    } sse_in_t;

    // result transaction
    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] out_y;
        logic [15:0] out_x;
        logic [15:0] out_pattern;
        logic [15:0] out_attr;
    } sse_out_t;

    // classified entry between front and back
    typedef struct packed {
        logic        start;
        logic        cand;
        logic [15:0] y_word;
        logic [15:0] x_word;
        logic [15:0] pattern_word;
        logic [15:0] attr;
    } sse_mid_t;

    // head of the classified queue
    typedef struct packed {
        logic     valid;
        sse_mid_t item;
    } sse_mid_head_t;

    // sprite height from attribute bits 13:12
    function automatic logic [6:0] height_of(input logic [1:0] code);
        logic [6:0] h;
        begin
            case (code)
                HCODE_32: h = 7'd32;
                HCODE_64: h = 7'd64;
                default:  h = 7'd16;
            endcase
            return h;
        end
    endfunction

endpackage

// ===== rtl/core/sse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_front
// Accepts attribute entries, checks visibility and queues classified entries.
// ----------------------------------------------------------------------------
module sse_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sse_pkg::sse_in_t      in_item,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    output sse_pkg::sse_mid_head_t head,
    input  logic                  head_pop
);
    import sse_pkg::*;

    logic                 enable_reg;
    sse_mid_t             mem_reg [MID_DEPTH];
    logic [MID_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [MID_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [MID_CNT_W-1:0] count_reg, count_next;

    logic signed [11:0] line_ext;
    logic signed [11:0] y_top;
    logic signed [11:0] y_end;
    logic               visible;
    logic               start;
    logic               do_push;
    logic               do_pop;
    sse_mid_t           cls;

    // enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b1;
        else if (cfg_we)
            enable_reg <= cfg_wdata;
    end

    // visibility window y <= line < y + height
    always_comb
    begin
        line_ext = {{2{in_item.line[9]}}, in_item.line};
        y_top    = signed'({2'b00, in_item.y_word[9:0] & Y_MASK}) - signed'(Y_OFFSET);
        y_end    = y_top + signed'({5'b0, height_of(in_item.attr_word[13:12])});
        visible  = (line_ext >= y_top) && (line_ext < y_end);
        start    = (in_item.entry_index == 6'd0);
    end

    // classified entry
    always_comb
    begin
        cls.start        = start;
        cls.cand         = enable_reg && !in_item.line[9] &&
                           ({3'b000, in_item.entry_index} < INDEX_LIMIT) && visible;
        cls.y_word       = in_item.y_word;
        cls.x_word       = in_item.x_word;
        cls.pattern_word = in_item.pattern_word;
        cls.attr         = (in_item.attr_word & ATTR_MASK) | (start ? ATTR_FIRST : 16'h0000);
    end

    // queue control
    always_comb
    begin
        full        = (count_reg == MID_CNT_W'(MID_DEPTH));
        do_push     = push && !full;
        do_pop      = head_pop && (count_reg != '0);
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + MID_CNT_W'(do_push) - MID_CNT_W'(do_pop);
        head.valid  = (count_reg != '0);
        head.item   = mem_reg[rd_ptr_reg];
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= cls;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MID_CNT_W'(MID_DEPTH))
        else $error("classified queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + MID_CNT_W'(1)))
        else $error("classified queue count did not advance on push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("classified queue pointers disagree when empty");

endmodule

// ===== rtl/core/sse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_back
// Slot allocation per line, overflow detection and the result queue.
// ----------------------------------------------------------------------------
module sse_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sse_pkg::sse_mid_head_t head,
    output logic                   head_pop,
    output logic                   empty,
    input  logic                   pop,
    output sse_pkg::sse_out_t      out_item
);
    import sse_pkg::*;

    logic [SLOT_CNT_W-1:0] used_reg, used_next;
    logic                  stopped_reg, stopped_next;

    sse_out_t              mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]  count_reg, count_next;

    logic [SLOT_CNT_W-1:0] used_cur;
    logic                  stopped_cur;
    logic                  emit;
    logic                  do_pop;
    logic                  out_full;
    sse_out_t              res;

    // take an entry whenever the result queue has room
    always_comb
    begin
        out_full = (count_reg == OUT_CNT_W'(OUT_DEPTH));
        head_pop = head.valid && !out_full;
    end

    // per-line slot state and result forming
    always_comb
    begin
        used_cur     = head.item.start ? '0 : used_reg;
        stopped_cur  = head.item.start ? 1'b0 : stopped_reg;
        used_next    = used_reg;
        stopped_next = stopped_reg;
        emit         = 1'b0;
        res          = '0;
        if (head_pop)
        begin
            used_next    = used_cur;
            stopped_next = stopped_cur;
            if (head.item.cand && !stopped_cur)
            begin
                emit = 1'b1;
                if (used_cur >= SLOT_CNT_W'(LINE_SLOTS))
                begin
                    stopped_next = 1'b1;
                    res.kind     = KIND_OVERFLOW;
                end
                else
                begin
                    res.kind        = KIND_STORE;
                    res.slot        = used_cur[3:0];
                    res.out_y       = head.item.y_word;
                    res.out_x       = head.item.x_word;
                    res.out_pattern = head.item.pattern_word;
                    res.out_attr    = head.item.attr;
                    used_next       = used_cur + SLOT_CNT_W'(1);
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            stopped_reg <= stopped_next;
        end
    end

    // result queue control
    always_comb
    begin
        empty       = (count_reg == '0);
        do_pop      = pop && !empty;
        wr_ptr_next = emit ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(emit) - OUT_CNT_W'(do_pop);
        out_item    = mem_reg[rd_ptr_reg];
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (emit)
            mem_reg[wr_ptr_reg] <= res;
    end

    // checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SLOT_CNT_W'(LINE_SLOTS))
        else $error("slot count beyond line capacity");

    a_overflow_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (res.kind == KIND_OVERFLOW)) |=> stopped_reg)
        else $error("overflow result did not stop the line");

    a_no_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_full)
        else $error("result written into a full queue");

    a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (head_pop && stopped_reg && !head.item.start) |-> !emit)
        else $error("result produced on a stopped line");

endmodule

// ===== rtl/core/sprite_scanline_evaluation.sv =====
`timescale 1ns / 1ps
// Path: an accepted entry that yields a result is registered in the classified
//   queue, then given a slot and registered in the result queue.
// Throughput: one entry per cycle while the result queue has room, set by the
//   slot allocation loop in the back end, which holds entries while it is full.
// Reset: line state cleared, queues empty, sprite evaluation enabled.
// ----------------------------------------------------------------------------
// sprite_scanline_evaluation
// Per-line sprite evaluation: picks up to sixteen visible sprites per line.
// ----------------------------------------------------------------------------
module sprite_scanline_evaluation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  sse_pkg::sse_in_t  in_item,
    output logic              empty,
    input  logic              pop,
    output sse_pkg::sse_out_t out_item,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);
    import sse_pkg::*;

    sse_mid_head_t head;
    logic          head_pop;

    // front end: accept and classify
    sse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .head_pop  (head_pop)
    );

    // back end: slot allocation and results
    sse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_pop (head_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// ===== bench/sprite_scanline_evaluation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_scanline_evaluation_tb
// Self-checking bench for per-line sprite evaluation. Attribute entries are
// queued as directed boundary cases and then as random scan lines, broken
// sequences and noise. A behavioral predictor tracks slot use and overflow
// per line, and every popped transaction is compared field by field. Both
// sides idle at random, and the result side holds off once for a long
// stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module sprite_scanline_evaluation_tb;

    import sse_pkg::*;

    localparam int LIMIT_NS      = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_AT      = 200;
    localparam int STALL_CYCLES  = 400;
    localparam int PRINT_CAP     = 40;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     push      = 1'b0;
    logic     full;
    sse_in_t  in_item   = '0;
    logic     empty;
    logic     pop       = 1'b0;
    sse_out_t out_item;
    logic     cfg_we    = 1'b0;
    logic     cfg_wdata = 1'b0;

    // stimulus and expectation stores
    sse_in_t  entry_queue[$];
    sse_out_t expected_writes[$];

    // predictor state
    logic [4:0] slots_used   = '0;
    logic       line_stopped = 1'b0;
    logic       sprites_on   = 1'b1;

    int mismatch_count = 0;
    int entries_taken  = 0;
    int send_idle_pct  = 31;
    int recv_idle_pct  = 79;
    int stall_left     = 0;
    bit stall_done     = 1'b0;

    sprite_scanline_evaluation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // sprite height from the attribute height code
    function automatic int sprite_height(logic [1:0] code);
        case (code)
            HCODE_32: return 32;
            HCODE_64: return 64;
            default:  return 16;
        endcase
    endfunction

    // predict the slot write or overflow caused by one accepted entry
    function automatic void evaluate_entry(sse_in_t e);
        int       ln;
        int       ytop;
        sse_out_t r;
        ln   = $signed(e.line);
        ytop = int'(e.y_word[9:0]) - 64;
        r    = '0;
        // entry zero opens a new line even when nothing is emitted
        if (e.entry_index == 6'd0)
        begin
            slots_used   = '0;
            line_stopped = 1'b0;
        end
        if (!sprites_on || ln < 0 || int'(e.entry_index) >= TABLE_ENTRIES || line_stopped)
            return;
        if (!(ln >= ytop && ln < ytop + sprite_height(e.attr_word[13:12])))
            return;
        // all slots taken: flag overflow once and stop the line
        if (int'(slots_used) >= LINE_SLOTS)
        begin
            line_stopped = 1'b1;
            r.kind       = KIND_OVERFLOW;
            expected_writes.push_back(r);
            return;
        end
        r.kind        = KIND_STORE;
        r.slot        = slots_used[3:0];
        r.out_y       = e.y_word;
        r.out_x       = e.x_word;
        r.out_pattern = e.pattern_word;
        r.out_attr    = e.attr_word & ATTR_MASK;
        if (e.entry_index == 6'd0)
            r.out_attr = r.out_attr | ATTR_FIRST;
        expected_writes.push_back(r);
        slots_used = slots_used + 5'd1;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // compare one popped transaction with the oldest expectation
    task automatic check_result(sse_out_t got);
        sse_out_t want;
        if (expected_writes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_writes.pop_front();
        if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.slot != want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
        if (got.out_y != want.out_y)
            report_mismatch($sformatf("out_y %h, want %h", got.out_y, want.out_y));
        if (got.out_x != want.out_x)
            report_mismatch($sformatf("out_x %h, want %h", got.out_x, want.out_x));
        if (got.out_pattern != want.out_pattern)
            report_mismatch($sformatf("out_pattern %h, want %h",
                                      got.out_pattern, want.out_pattern));
        if (got.out_attr != want.out_attr)
            report_mismatch($sformatf("out_attr %h, want %h", got.out_attr, want.out_attr));
    endtask

    // input driver: offers queued entries, holds while the block is full
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                evaluate_entry(in_item);
                entries_taken <= entries_taken + 1;
            end
            if (!push || !full)
            begin
                if (entry_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    push    <= 1'b1;
                    in_item <= entry_queue.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result monitor: checks each popped transaction, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_result(out_item);
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                pop        <= 1'b0;
            end
            else if (!stall_done && entries_taken >= STALL_AT)
            begin
                stall_left <= STALL_CYCLES;
                stall_done <= 1'b1;
                pop        <= 1'b0;
            end
            else
                pop <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // entry whose top row is ytop, low word bits carry ytop + 64
    function automatic sse_in_t entry_at(int ln, int idx, int ytop, logic [15:0] attr,
                                         logic [15:0] xw, logic [15:0] pw);
        sse_in_t e;
        e.line         = 10'(ln);
        e.entry_index  = 6'(idx);
        e.y_word       = {6'b0, 10'(ytop + 64)};
        e.x_word       = xw;
        e.pattern_word = pw;
        e.attr_word    = attr;
        return e;
    endfunction

    // random entry that covers the line or just misses it
    function automatic sse_in_t make_entry(int ln, int idx, bit visible);
        logic [15:0] attr;
        int          h;
        int          off;
        sse_in_t     e;
        attr = 16'($urandom);
        h    = sprite_height(attr[13:12]);
        if (visible)
            off = $urandom_range(h - 1, 0);
        else if ($urandom_range(1, 0) == 0)
            off = h + $urandom_range(20, 0);
        else
            off = -1 - $urandom_range(20, 0);
        e = entry_at(ln, idx, ln - off, attr, 16'($urandom), 16'($urandom));
        e.y_word[15:10] = 6'($urandom);
        return e;
    endfunction

    // boundary rows, every height code, overflow and extremes
    task automatic queue_directed();
        logic [15:0] attr;
        int          h;
        int          ytop;
        sse_in_t     e;
        entry_queue.push_back(entry_at(200, 0, 200, 16'hFFFF, 16'hFFFF, 16'h0000));
        // eighteen visible entries on one line: the seventeenth overflows, the last is dropped
        for (int i = 1; i < 20; i++)
        begin
            attr = {2'b10, 2'(i), 12'hA35};
            h    = sprite_height(attr[13:12]);
            if (i == 5)
                ytop = 201;
            else if (i == 11)
                ytop = 200 - h;
            else if (i % 2 == 0)
                ytop = 200;
            else
                ytop = 200 - h + 1;
            entry_queue.push_back(entry_at(200, i, ytop, attr,
                                           (i % 2 != 0) ? 16'hFFFF : 16'h0000,
                                           (i % 2 != 0) ? 16'h0000 : 16'hFFFF));
        end
        // negative lines still restart the line on entry zero
        entry_queue.push_back(entry_at(-1, 0, -1, 16'h0000, 16'h1234, 16'h5678));
        entry_queue.push_back(entry_at(-512, 1, -512, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        e = entry_at(511, 2, 511, 16'h0000, 16'h0000, 16'hFFFF);
        e.y_word[15:10] = 6'h3F;
        entry_queue.push_back(e);
        entry_queue.push_back(entry_at(0, 3, 0, 16'h3000, 16'hAAAA, 16'h5555));
        e = entry_at(100, 4, 959, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        e.y_word = 16'hFFFF;
        entry_queue.push_back(e);
    endtask

    // random scan lines, broken runs and noise
    task automatic queue_random(int target);
        int          added;
        int          kind_pick;
        int          ln;
        int          n;
        int          vis_pct;
        logic [95:0] bits;
        added = 0;
        while (added < target)
        begin
            kind_pick = $urandom_range(99, 0);
            if (kind_pick < 75)
            begin
                // well-formed line starting at entry zero
                ln = ($urandom_range(9, 0) == 0) ? -int'($urandom_range(512, 1))
                                                 : int'($urandom_range(511, 0));
                n  = ($urandom_range(3, 0) == 0) ? int'($urandom_range(63, 1)) : 64;
                case ($urandom_range(2, 0))
                    0:       vis_pct = 5;
                    1:       vis_pct = 30;
                    default: vis_pct = 75;
                endcase
                for (int i = 0; i < n; i++)
                    entry_queue.push_back(make_entry(ln, i, $urandom_range(99, 0) < vis_pct));
                added += n;
            end
            else if (kind_pick < 90)
            begin
                // out-of-order indices on one line
                ln = $urandom_range(511, 0);
                n  = $urandom_range(16, 1);
                for (int i = 0; i < n; i++)
                    entry_queue.push_back(make_entry(ln, $urandom_range(63, 0),
                                                     $urandom_range(1, 0) == 0));
                added += n;
            end
            else
            begin
                // fully random entries
                n = $urandom_range(10, 1);
                for (int i = 0; i < n; i++)
                begin
                    bits = {$urandom, $urandom, $urandom};
                    entry_queue.push_back(sse_in_t'(bits[79:0]));
                end
                added += n;
            end
        end
    endtask

    // wait until every entry is taken and every result has been popped
    task automatic wait_drained();
        while (entry_queue.size() != 0 || push || expected_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // enable register write, only while the block is idle
    task automatic write_enable(logic value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sprites_on  = value;
    endtask

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_enable(1'b1);

        // sender idles lightly, receiver heavily
        @(negedge clk);
        queue_directed();
        queue_random(800);
        wait_drained();

        // evaluation disabled: nothing may come out
        write_enable(1'b0);
        @(negedge clk);
        queue_random(100);
        wait_drained();

        // sender idles heavily, receiver lightly
        write_enable(1'b1);
        @(negedge clk);
        send_idle_pct = 79;
        recv_idle_pct = 31;
        queue_random(750);
        wait_drained();

        // back to back on both sides
        @(negedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(300);
        wait_drained();

        // nothing may be left waiting in the block
        if (!empty)
            report_mismatch("result left in the block after the last entry");

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
